FILE: rtl/btp_pkg.sv
// Shared types, character codes and limits for the bencode token parser.
// No dependencies; every other rtl file except btp_ram imports this package.
package btp_pkg;

   // Default nesting depth and fixed syntax limits
   localparam int MAX_NESTING_DEF = 32;
   localparam int MAX_INT_CHARS   = 20;
   localparam int MAX_LEN_DIGITS  = 10;

   localparam logic [31:0] BUDGET_RESET = 32'd16777216;

   // Characters with meaning in the grammar
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   // floor((2^63 - 1) / 10); the per-digit overflow bound is this or one less
   localparam logic [63:0] INT_SAT_Q = 64'd922337203685477580;
   localparam logic [63:0] INT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_MIN   = 64'h8000_0000_0000_0000;

   typedef enum logic [3:0] {
      PH_VALUE = 4'd0,
      PH_KEY   = 4'd1,
      PH_ISIGN = 4'd2,
      PH_INEG  = 4'd3,
      PH_IZERO = 4'd4,
      PH_IDIG  = 4'd5,
      PH_LEN   = 4'd6,
      PH_STR   = 4'd7,
      PH_DONE  = 4'd8
   } phase_type;

   // Container kind held per nesting level
   typedef enum logic [1:0] {
      SK_NONE = 2'd0,
      SK_LIST = 2'd1,
      SK_DKEY = 2'd2,
      SK_DVAL = 2'd3
   } sk_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EARLY   = 3'd1,
      ST_CORRUPT = 3'd2,
      ST_TRAIL   = 3'd3,
      ST_DEEP    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      TK_NONE  = 3'd0,
      TK_INT   = 3'd1,
      TK_SHDR  = 3'd2,
      TK_SBYTE = 3'd3,
      TK_LIST  = 3'd4,
      TK_DICT  = 3'd5,
      TK_CLOSE = 3'd6
   } kind_type;

   // Parser state outside the nesting stack
   typedef struct packed {
      phase_type   phase;
      logic [63:0] num_accum;
      logic        num_neg;
      logic        num_sat;
      logic [4:0]  digit_count;
      logic [33:0] bytes_left;
      logic [32:0] budget_used;
      status_type  err_code;
      logic        top_complete;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:        PH_VALUE,
      num_accum:    64'd0,
      num_neg:      1'b0,
      num_sat:      1'b0,
      digit_count:  5'd0,
      bytes_left:   34'd0,
      budget_used:  33'd0,
      err_code:     ST_OK,
      top_complete: 1'b0
   };

   // Stack update requested by the decoder; set rewrites the top after any pop
   typedef struct packed {
      logic   clear;
      logic   push;
      logic   pop;
      logic   set;
      sk_type kind;
   } stack_op_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] value;
      logic [5:0]  nest_level;
      status_type  status;
      logic        done;
   } result_type;

endpackage

FILE: rtl/btp_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module btp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/btp_nest_stack.sv
// Nesting stack: top entry in a register, lower entries in a RAM whose
// read port always prefetches the entry under the top. Uses btp_pkg, btp_ram.
module btp_nest_stack #(
   parameter int MAX_NESTING = btp_pkg::MAX_NESTING_DEF,
   localparam int PW         = $clog2(MAX_NESTING + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  btp_pkg::stack_op_type op,
   output logic [PW-1:0]         ptr,
   output btp_pkg::sk_type       top,
   output btp_pkg::sk_type       under
);
   import btp_pkg::*;

   localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

   logic [PW-1:0] ptr_ff, ptr_in;
   sk_type        top_ff, top_in;
   logic          byp_vld_ff, byp_vld_in;
   sk_type        byp_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    rd_data;
   logic [PW-1:0] ptr_m1, ptr_in_m2;

   // Pointer and top-of-stack next values
   always_comb begin
      ptr_in = ptr_ff;
      top_in = top_ff;
      if (enable) begin
         if (op.clear) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + PW'(op.push) - PW'(op.pop);
         end
         if (op.push || op.set) begin
            top_in = op.kind;
         end else if (op.pop) begin
            top_in = under;
         end
      end
   end

   // Push spills the old top below; read side tracks the new under-top slot
   assign ptr_m1    = ptr_ff - PW'(1);
   assign ptr_in_m2 = ptr_in - PW'(2);
   assign wr_en     = enable && op.push && (ptr_ff != '0);
   assign wr_addr   = ptr_m1[AW-1:0];
   assign rd_addr   = (ptr_in >= PW'(2)) ? ptr_in_m2[AW-1:0] : '0;
   assign byp_vld_in = wr_en && (wr_addr == rd_addr);

   btp_ram #(
      .WIDTH (2),
      .DEPTH (MAX_NESTING)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         byp_vld_ff <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         byp_vld_ff <= byp_vld_in;
      end
      top_ff      <= top_in;
      byp_data_ff <= top_ff;
   end

   assign ptr   = ptr_ff;
   assign top   = top_ff;
   assign under = byp_vld_ff ? byp_data_ff : sk_type'(rd_data);

endmodule

FILE: rtl/btp_decode.sv
// Per-byte decode: next parser state, stack update and the token for one beat.
// Purely combinational. Uses btp_pkg.
module btp_decode #(
   parameter int MAX_NESTING = btp_pkg::MAX_NESTING_DEF,
   localparam int PW         = $clog2(MAX_NESTING + 1)
) (
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   input  btp_pkg::parse_state_type st,
   input  logic [PW-1:0]            ptr,
   input  btp_pkg::sk_type          top,
   input  btp_pkg::sk_type          under,
   input  logic [31:0]              budget,
   output btp_pkg::parse_state_type st_next,
   output btp_pkg::stack_op_type    op,
   output btp_pkg::result_type      result
);
   import btp_pkg::*;

   logic          is_dig;
   logic [3:0]    dgt;
   logic [63:0]   sat_lim, acc10;
   logic          acc_over;
   logic [33:0]   len10;
   logic          go_close, go_start, go_add, go_emit, len_colon;
   logic          do_vd, vd_close, v_zero, v_chg;
   sk_type        v_top;
   logic          chg_en;
   logic [33:0]   chg_amt;
   logic [34:0]   chg_sum;
   logic          chg_over;
   status_type    fail_code, err_after;
   kind_type      kind;
   logic [63:0]   value;
   logic [PW-1:0] ptr_after;
   logic [PW+5:0] lvl_ext;

   // Digit helpers and the two multiply-by-ten paths
   assign is_dig   = in_byte inside {[CH_0:CH_9]};
   assign dgt      = in_byte[3:0];
   assign sat_lim  = INT_SAT_Q - 64'(dgt > (st.num_neg ? 4'd8 : 4'd7));
   assign acc_over = st.num_accum > sat_lim;
   assign acc10    = (st.num_accum << 3) + (st.num_accum << 1) + 64'(dgt);
   assign len10    = (st.bytes_left << 3) + (st.bytes_left << 1) + 34'(dgt);

   always_comb begin
      st_next   = st;
      op        = '0;
      op.kind   = SK_NONE;
      kind      = TK_NONE;
      value     = '0;
      fail_code = ST_OK;
      go_close  = 1'b0;
      go_start  = 1'b0;
      go_add    = 1'b0;
      go_emit   = 1'b0;
      len_colon = 1'b0;
      do_vd     = 1'b0;
      vd_close  = 1'b0;
      v_zero    = 1'b0;
      v_top     = SK_NONE;
      v_chg     = 1'b0;
      chg_en    = 1'b0;
      chg_amt   = '0;
      chg_sum   = '0;
      chg_over  = 1'b0;

      if (st.err_code == ST_OK) begin
         // Phase dispatch
         case (st.phase)
            PH_VALUE: begin
               if (in_byte == CH_E && ptr != '0 && top == SK_LIST) begin
                  go_close = 1'b1;
               end else begin
                  go_start = 1'b1;
               end
            end
            PH_KEY: begin
               if (in_byte == CH_E) begin
                  go_close = 1'b1;
               end else if (is_dig) begin
                  go_start = 1'b1;
               end else begin
                  fail_code = ST_CORRUPT;
               end
            end
            PH_ISIGN: begin
               if (in_byte == CH_MINUS) begin
                  st_next.num_neg     = 1'b1;
                  st_next.digit_count = 5'd1;
                  st_next.phase       = PH_INEG;
               end else if (in_byte == CH_0) begin
                  st_next.digit_count = st.digit_count + 5'd1;
                  st_next.phase       = PH_IZERO;
               end else if (is_dig) begin
                  go_add        = 1'b1;
                  st_next.phase = PH_IDIG;
               end else begin
                  fail_code = ST_CORRUPT;
               end
            end
            PH_INEG: begin
               if (is_dig && in_byte != CH_0) begin
                  go_add        = 1'b1;
                  st_next.phase = PH_IDIG;
               end else begin
                  fail_code = ST_CORRUPT;
               end
            end
            PH_IZERO: begin
               if (in_byte == CH_E) begin
                  go_emit = 1'b1;
               end else begin
                  fail_code = ST_CORRUPT;
               end
            end
            PH_IDIG: begin
               if (in_byte == CH_E) begin
                  go_emit = 1'b1;
               end else if (is_dig && st.digit_count < 5'(MAX_INT_CHARS)) begin
                  go_add = 1'b1;
               end else begin
                  fail_code = ST_CORRUPT;
               end
            end
            PH_LEN: begin
               if (in_byte == CH_COLON) begin
                  len_colon = 1'b1;
                  kind      = TK_SHDR;
                  value     = 64'(st.bytes_left);
               end else if (is_dig && !(st.digit_count == 5'd1 && st.bytes_left == '0)
                            && st.digit_count < 5'(MAX_LEN_DIGITS)) begin
                  st_next.digit_count = st.digit_count + 5'd1;
                  st_next.bytes_left  = len10;
               end else begin
                  fail_code = ST_CORRUPT;
               end
            end
            PH_STR: begin
               kind               = TK_SBYTE;
               value              = 64'(in_byte);
               st_next.bytes_left = st.bytes_left - 34'd1;
               do_vd              = (st.bytes_left == 34'd1);
            end
            default: begin
               fail_code = ST_TRAIL;
            end
         endcase

         // Start of a new value: integer, container or string length
         if (go_start) begin
            if (in_byte == CH_I) begin
               st_next.num_accum   = '0;
               st_next.num_neg     = 1'b0;
               st_next.num_sat     = 1'b0;
               st_next.digit_count = '0;
               st_next.phase       = PH_ISIGN;
            end else if (in_byte == CH_L || in_byte == CH_D) begin
               if (ptr >= PW'(MAX_NESTING)) begin
                  fail_code = ST_DEEP;
               end else begin
                  op.push = 1'b1;
                  if (in_byte == CH_L) begin
                     op.kind       = SK_LIST;
                     kind          = TK_LIST;
                     st_next.phase = PH_VALUE;
                  end else begin
                     op.kind       = SK_DKEY;
                     kind          = TK_DICT;
                     st_next.phase = PH_KEY;
                  end
               end
            end else if (is_dig) begin
               st_next.bytes_left  = 34'(dgt);
               st_next.digit_count = 5'd1;
               st_next.phase       = PH_LEN;
            end else begin
               fail_code = ST_CORRUPT;
            end
         end

         if (go_close) begin
            op.pop   = 1'b1;
            kind     = TK_CLOSE;
            do_vd    = 1'b1;
            vd_close = 1'b1;
         end

         // Integer digit with saturation
         if (go_add) begin
            st_next.digit_count = st.digit_count + 5'd1;
            if (!st.num_sat) begin
               if (acc_over) begin
                  st_next.num_sat = 1'b1;
               end else begin
                  st_next.num_accum = acc10;
               end
            end
         end

         if (go_emit) begin
            kind  = TK_INT;
            do_vd = 1'b1;
            if (st.num_sat) begin
               value = st.num_neg ? INT_MIN : INT_MAX;
            end else begin
               value = st.num_neg ? (64'd0 - st.num_accum) : st.num_accum;
            end
         end

         // Enclosing container after a finished value
         v_zero = vd_close ? (ptr == PW'(1)) : (ptr == '0);
         v_top  = vd_close ? under : top;
         v_chg  = !v_zero && v_top != SK_DKEY;

         // Allocation budget: string length, or one element per finished list item or dict value
         chg_en  = len_colon || (do_vd && v_chg);
         chg_amt = len_colon ? ((st.bytes_left != '0) ? st.bytes_left : 34'(v_chg))
                             : 34'd1;
         chg_sum  = 35'(st.budget_used) + 35'(chg_amt);
         chg_over = chg_sum > 35'(budget);
         if (chg_en) begin
            if (chg_over) begin
               fail_code = ST_CORRUPT;
            end else begin
               st_next.budget_used = chg_sum[32:0];
            end
         end

         if (len_colon && !chg_over) begin
            if (st.bytes_left == '0) begin
               do_vd = 1'b1;
            end else begin
               st_next.phase = PH_STR;
            end
         end

         if (do_vd) begin
            if (v_zero) begin
               st_next.top_complete = 1'b1;
               st_next.phase        = PH_DONE;
            end else if (v_top == SK_DKEY) begin
               op.set        = 1'b1;
               op.kind       = SK_DVAL;
               st_next.phase = PH_VALUE;
            end else if (v_top == SK_DVAL) begin
               op.set        = 1'b1;
               op.kind       = SK_DKEY;
               st_next.phase = PH_KEY;
            end else begin
               st_next.phase = PH_VALUE;
            end
         end
      end

      // Sticky error, token suppression and end-of-document check
      err_after = (st.err_code != ST_OK) ? st.err_code : fail_code;
      if (err_after != ST_OK) begin
         kind  = TK_NONE;
         value = '0;
      end
      if (in_last && err_after == ST_OK && !st_next.top_complete) begin
         err_after = ST_EARLY;
      end
      st_next.err_code = err_after;

      ptr_after = ptr + PW'(op.push) - PW'(op.pop);
      lvl_ext   = {6'd0, ptr_after};

      result.kind       = kind;
      result.value      = value;
      result.nest_level = lvl_ext[5:0];
      result.status     = err_after;
      result.done       = in_last;

      // Final byte restarts the parse
      if (in_last) begin
         st_next  = PARSE_RESET;
         op.clear = 1'b1;
      end
   end

endmodule

FILE: rtl/bencode_token_parser.sv
// Bencode token parser: one document byte per beat in, one token per beat out,
// with one result for every byte and a sticky status that restarts after the
// beat flagged last. One byte per clock passes the input register, then decode
// into the result register, unless rsp_stall holds a result. The nesting stack
// keeps its top entry in a register and the rest in a RAM of MAX_NESTING
// two-bit entries whose read port always prefetches the entry under the top,
// so opens and closes also sustain one byte per clock. No clearing pass is
// needed after reset. Depends on btp_pkg, btp_decode, btp_nest_stack, btp_ram.
module bencode_token_parser #(
   parameter int MAX_NESTING = btp_pkg::MAX_NESTING_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_in_last,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_token_kind,
   output logic signed [63:0] rsp_token_value,
   output logic [5:0]         rsp_nest_level,
   output logic [2:0]         rsp_parse_status,
   output logic               rsp_doc_done,
   // budget register
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);
   import btp_pkg::*;

   localparam int PW = $clog2(MAX_NESTING + 1);

   logic            a_valid_ff, a_valid_in;
   logic [7:0]      a_byte_ff;
   logic            a_last_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      result_ff, result_in;
   parse_state_type state_ff, state_in;
   logic [31:0]     budget_ff;
   logic            accept, fire;
   stack_op_type    stack_op;
   logic [PW-1:0]   nest_ptr;
   sk_type          stack_top, stack_under;

   // Handshake: the input register moves on whenever the result slot frees up
   assign fire         = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = a_valid_ff && !fire;
   assign accept       = req_valid && !req_stall;
   assign a_valid_in   = accept || (a_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   btp_decode #(
      .MAX_NESTING (MAX_NESTING)
   ) u_decode (
      .in_byte (a_byte_ff),
      .in_last (a_last_ff),
      .st      (state_ff),
      .ptr     (nest_ptr),
      .top     (stack_top),
      .under   (stack_under),
      .budget  (budget_ff),
      .st_next (state_in),
      .op      (stack_op),
      .result  (result_in)
   );

   btp_nest_stack #(
      .MAX_NESTING (MAX_NESTING)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .enable (fire),
      .op     (stack_op),
      .ptr    (nest_ptr),
      .top    (stack_top),
      .under  (stack_under)
   );

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= PARSE_RESET;
         budget_ff    <= BUDGET_RESET;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
      end
   end

   // Beat payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a_byte_ff <= req_in_byte;
         a_last_ff <= req_in_last;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = result_ff.kind;
   assign rsp_token_value  = $signed(result_ff.value);
   assign rsp_nest_level   = result_ff.nest_level;
   assign rsp_parse_status = result_ff.status;
   assign rsp_doc_done     = result_ff.done;

`ifndef NO_ASSERTIONS
   // Final byte of a document leaves a clean parser and an empty stack
   a_restart: assert property (@(posedge clock) disable iff (reset)
      fire && a_last_ff |=> state_ff.err_code == ST_OK && nest_ptr == '0)
      else $error("parser did not restart after last byte");

   // Error code holds until the document ends
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      fire && !a_last_ff && state_ff.err_code != ST_OK
      |=> state_ff.err_code == $past(state_ff.err_code))
      else $error("error code changed before end of document");

   // A waiting input beat is neither dropped nor altered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !fire |=> a_valid_ff && $stable(a_byte_ff) && $stable(a_last_ff))
      else $error("pending input beat lost");
`endif

endmodule

FILE: verif/tb_bencode_token_parser.sv
// Self-checking testbench for bencode_token_parser: random and directed bencode
// documents, a token predictor kept in step with the budget register, and checks on
// every result beat. Depends on btp_pkg and the bencode_token_parser RTL.
`timescale 1ns / 100ps

module tb_bencode_token_parser;
   import btp_pkg::*;

   localparam int MAX_DEPTH    = MAX_NESTING_DEF;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 4;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PRINT_CAP    = 100;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } doc_beat_type;

   // clock, reset and block ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_in_byte = 8'd0;
   logic               req_in_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_token_kind;
   logic signed [63:0] rsp_token_value;
   logic [5:0]         rsp_nest_level;
   logic [2:0]         rsp_parse_status;
   logic               rsp_doc_done;
   logic               csr_wr_en = 1'b0;
   logic [31:0]        csr_wr_data = 32'd0;

   // stimulus and scoreboard
   doc_beat_type feed_q [$];
   result_type   token_q [$];
   logic [7:0]   doc_buf [$];
   bit           idle_on = 1'b1;
   int           hold_req = 0;
   int           errors = 0;
   int           bytes_queued = 0;
   int           bytes_sent = 0;
   int           docs_sent = 0;
   int           tokens_checked = 0;
   int           budgets_set = 0;
   int           deepest = 0;
   int           cycle_count = 0;

   string int_edges [0:6] = '{
      "0", "9223372036854775807", "-9223372036854775808", "9223372036854775808",
      "-9223372036854775809", "99999999999999999999", "-9999999999999999999"
   };
   string bad_forms [0:5] = '{"i-0e", "i01e", "ie", "i-e", "i--1e", "ei"};

   // token predictor state
   phase_type   doc_phase;
   sk_type      doc_stack [MAX_DEPTH];
   int unsigned doc_depth;
   logic [63:0] num_acc;
   logic        num_neg;
   logic        num_sat;
   int unsigned num_chars;
   logic [63:0] str_left;
   logic [63:0] spent;
   status_type  doc_status;
   logic        doc_complete;
   logic [31:0] budget_limit = BUDGET_RESET;
   kind_type    tok_kind;
   logic [63:0] tok_value;

   bencode_token_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_value  (rsp_token_value),
      .rsp_nest_level   (rsp_nest_level),
      .rsp_parse_status (rsp_parse_status),
      .rsp_doc_done     (rsp_doc_done),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void doc_restart();
      doc_phase    = PH_VALUE;
      doc_depth    = 0;
      num_acc      = 64'd0;
      num_neg      = 1'b0;
      num_sat      = 1'b0;
      num_chars    = 0;
      str_left     = 64'd0;
      spent        = 64'd0;
      doc_status   = ST_OK;
      doc_complete = 1'b0;
   endfunction

   // first error wins
   function automatic void raise(status_type code);
      if (doc_status == ST_OK)
         doc_status = code;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= CH_0 && b <= CH_9;
   endfunction

   // charge n units against the budget; a lowered budget below spent always fails
   function automatic bit spend(logic [63:0] n);
      logic [63:0] lim;
      lim = {32'd0, budget_limit};
      if (spent > lim || n > lim - spent) begin
         raise(ST_CORRUPT);
         return 1'b0;
      end
      spent += n;
      return 1'b1;
   endfunction

   // a value finished: advance the enclosing container or mark the document whole
   function automatic void value_end();
      sk_type top;
      if (doc_depth == 0) begin
         doc_complete = 1'b1;
         doc_phase = PH_DONE;
         return;
      end
      top = doc_stack[doc_depth - 1];
      if (top == SK_DKEY) begin
         doc_stack[doc_depth - 1] = SK_DVAL;
         doc_phase = PH_VALUE;
         return;
      end
      void'(spend(64'd1));
      if (top == SK_DVAL) begin
         doc_stack[doc_depth - 1] = SK_DKEY;
         doc_phase = PH_KEY;
      end else begin
         doc_phase = PH_VALUE;
      end
   endfunction

   function automatic void open_level(sk_type kind);
      if (doc_depth >= MAX_DEPTH) begin
         raise(ST_DEEP);
         return;
      end
      doc_stack[doc_depth] = kind;
      doc_depth++;
      tok_kind = (kind == SK_LIST) ? TK_LIST : TK_DICT;
      doc_phase = (kind == SK_LIST) ? PH_VALUE : PH_KEY;
   endfunction

   function automatic void close_level();
      doc_depth--;
      tok_kind = TK_CLOSE;
      value_end();
   endfunction

   function automatic void start_value(logic [7:0] b);
      if (b == CH_I) begin
         num_acc = 64'd0;
         num_neg = 1'b0;
         num_sat = 1'b0;
         num_chars = 0;
         doc_phase = PH_ISIGN;
      end else if (b == CH_L) begin
         open_level(SK_LIST);
      end else if (b == CH_D) begin
         open_level(SK_DKEY);
      end else if (is_digit(b)) begin
         str_left = 64'(b - CH_0);
         num_chars = 1;
         doc_phase = PH_LEN;
      end else begin
         raise(ST_CORRUPT);
      end
   endfunction

   // decimal accumulate with saturation at the signed 64-bit bound
   function automatic void add_digit(logic [7:0] b);
      logic [63:0] d;
      logic [63:0] lim;
      d = 64'(b - CH_0);
      lim = num_neg ? INT_MIN : INT_MAX;
      num_chars++;
      if (num_sat)
         return;
      if (num_acc > (lim - d) / 64'd10)
         num_sat = 1'b1;
      else
         num_acc = num_acc * 64'd10 + d;
   endfunction

   function automatic void emit_int();
      tok_kind = TK_INT;
      if (num_sat)
         tok_value = num_neg ? INT_MIN : INT_MAX;
      else
         tok_value = num_neg ? 64'd0 - num_acc : num_acc;
      value_end();
   endfunction

   function automatic void consume(logic [7:0] b);
      case (doc_phase)
         PH_VALUE: begin
            if (b == CH_E && doc_depth > 0 && doc_stack[doc_depth - 1] == SK_LIST)
               close_level();
            else
               start_value(b);
         end
         PH_KEY: begin
            if (b == CH_E)
               close_level();
            else if (is_digit(b))
               start_value(b);
            else
               raise(ST_CORRUPT);
         end
         PH_ISIGN: begin
            if (b == CH_MINUS) begin
               num_neg = 1'b1;
               num_chars = 1;
               doc_phase = PH_INEG;
            end else if (b == CH_0) begin
               num_chars++;
               doc_phase = PH_IZERO;
            end else if (is_digit(b)) begin
               add_digit(b);
               doc_phase = PH_IDIG;
            end else begin
               raise(ST_CORRUPT);
            end
         end
         PH_INEG: begin
            if (is_digit(b) && b != CH_0) begin
               add_digit(b);
               doc_phase = PH_IDIG;
            end else begin
               raise(ST_CORRUPT);
            end
         end
         PH_IZERO: begin
            if (b == CH_E)
               emit_int();
            else
               raise(ST_CORRUPT);
         end
         PH_IDIG: begin
            if (b == CH_E)
               emit_int();
            else if (is_digit(b) && num_chars < MAX_INT_CHARS)
               add_digit(b);
            else
               raise(ST_CORRUPT);
         end
         PH_LEN: begin
            if (b == CH_COLON) begin
               tok_kind = TK_SHDR;
               tok_value = str_left;
               if (spend(str_left)) begin
                  if (str_left == 64'd0)
                     value_end();
                  else
                     doc_phase = PH_STR;
               end
            end else if (is_digit(b) && !(num_chars == 1 && str_left == 64'd0)
                         && num_chars < MAX_LEN_DIGITS) begin
               num_chars++;
               str_left = str_left * 64'd10 + 64'(b - CH_0);
            end else begin
               raise(ST_CORRUPT);
            end
         end
         PH_STR: begin
            tok_kind = TK_SBYTE;
            tok_value = 64'(b);
            str_left--;
            if (str_left == 64'd0)
               value_end();
         end
         default: raise(ST_TRAIL);
      endcase
   endfunction

   // expected token for one accepted byte
   function automatic result_type predict_token(logic [7:0] b, logic last);
      result_type r;
      tok_kind = TK_NONE;
      tok_value = 64'd0;
      if (doc_status == ST_OK)
         consume(b);
      if (doc_status != ST_OK) begin
         tok_kind = TK_NONE;
         tok_value = 64'd0;
      end
      if (last && doc_status == ST_OK && !doc_complete)
         doc_status = ST_EARLY;
      r.kind = tok_kind;
      r.value = tok_value;
      r.nest_level = 6'(doc_depth);
      r.status = doc_status;
      r.done = last;
      if (last)
         doc_restart();
      return r;
   endfunction

   // ---------------------------------------------------------------- document builders

   function automatic void add_byte(logic [7:0] b);
      doc_buf.insert(doc_buf.size(), b);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   function automatic void put_int();
      longint v;
      string  s;
      int     n;
      case ($urandom_range(0, 5))
         0, 1: begin
            v = longint'($urandom_range(0, 2000)) - 1000;
            s = $sformatf("%0d", v);
         end
         2: begin
            v = {$urandom, $urandom};
            s = $sformatf("%0d", v);
         end
         3: s = int_edges[$urandom_range(0, 6)];
         default: begin
            // random digit run, sometimes past the character limit
            n = $urandom_range(1, 21);
            if ($urandom_range(0, 1) != 0)
               s = "-";
            else
               s = "";
            s = {s, $sformatf("%0d", $urandom_range(1, 9))};
            repeat (n - 1)
               s = {s, $sformatf("%0d", $urandom_range(0, 9))};
         end
      endcase
      put_text({"i", s, "e"});
   endfunction

   function automatic void put_str();
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 4);
      put_text($sformatf("%0d:", len));
      repeat (len)
         add_byte(8'($urandom_range(0, 255)));
   endfunction

   // length with 9 to 11 digits, followed by a few bytes only
   function automatic void put_long_len();
      int n;
      n = $urandom_range(9, 11);
      put_text($sformatf("%0d", $urandom_range(1, 9)));
      repeat (n - 1)
         put_text($sformatf("%0d", $urandom_range(0, 9)));
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 3))
         add_byte(8'($urandom_range(0, 255)));
   endfunction

   // nested lists and single-key dicts, optionally closed again
   function automatic void put_deep(int levels, bit closed);
      repeat (levels) begin
         if ($urandom_range(0, 2) == 0)
            put_text("d1:k");
         else
            add_byte(CH_L);
      end
      if (closed)
         repeat (levels) add_byte(CH_E);
   endfunction

   function automatic void gen_value(int level);
      int n;
      case (level >= 3 ? $urandom_range(0, 1) : $urandom_range(0, 3))
         0: put_int();
         1: put_str();
         2: begin
            add_byte(CH_L);
            n = $urandom_range(0, 3);
            repeat (n) gen_value(level + 1);
            add_byte(CH_E);
         end
         default: begin
            add_byte(CH_D);
            n = $urandom_range(0, 3);
            repeat (n) begin
               put_str();
               gen_value(level + 1);
            end
            add_byte(CH_E);
         end
      endcase
   endfunction

   // move the built bytes to the feed; optionally damage them first
   function automatic void send_doc(bit mutate, bit closed);
      doc_beat_type nb;
      int           k;
      if (mutate) begin
         case ($urandom_range(0, 2))
            0: doc_buf[$urandom_range(0, doc_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
               k = $urandom_range(1, doc_buf.size());
               while (doc_buf.size() > k)
                  void'(doc_buf.pop_back());
            end
            default: add_byte(8'($urandom_range(0, 255)));
         endcase
      end
      for (int i = 0; i < doc_buf.size(); i++) begin
         nb.data = doc_buf[i];
         nb.last = closed && (i == doc_buf.size() - 1);
         feed_q.insert(feed_q.size(), nb);
      end
      bytes_queued += doc_buf.size();
      doc_buf.delete();
   endfunction

   function automatic void send_text(string s);
      put_text(s);
      send_doc(1'b0, 1'b1);
   endfunction

   function automatic void make_random_doc();
      int pick;
      pick = $urandom_range(0, 39);
      if (pick < 35) begin
         gen_value(0);
         send_doc(pick >= 30, 1'b1);
      end else if (pick < 37) begin
         repeat ($urandom_range(1, 6))
            add_byte(8'($urandom_range(0, 255)));
         send_doc(1'b0, 1'b1);
      end else if (pick == 37) begin
         put_long_len();
         send_doc(1'b0, 1'b1);
      end else if (pick == 38) begin
         put_deep($urandom_range(31, 34), 1'($urandom_range(0, 1)));
         send_doc(1'b0, 1'b1);
      end else begin
         send_text(bad_forms[$urandom_range(0, 5)]);
      end
   endfunction

   // ---------------------------------------------------------------- sequencing

   task automatic wait_drained();
      @(negedge clock);
      while (feed_q.size() != 0 || req_valid || token_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_budget(logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      budget_limit = value;
      budgets_set++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // keep a short backlog in front of the driver; flip idling between documents
   task automatic feed_random(int nbytes, bit bursts);
      int start;
      start = bytes_queued;
      idle_on = bursts;
      while (bytes_queued - start < nbytes) begin
         while (feed_q.size() > 12)
            @(negedge clock);
         make_random_doc();
         if (bursts && $urandom_range(0, 3) == 0)
            idle_on = !idle_on;
      end
   endtask

   task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t: token %0d %s mismatch: got 0x%0h, expected 0x%0h",
                  $time, tokens_checked, what, got, want);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      doc_beat_type nb;
      int           src_gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_in_byte <= 8'd0;
         req_in_last <= 1'b0;
         src_gap = 0;
      end else begin
         // predict on the accepted beat
         if (req_valid && !req_stall) begin
            token_q.insert(token_q.size(), predict_token(req_in_byte, req_in_last));
            bytes_sent++;
            if (req_in_last)
               docs_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (src_gap != 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (feed_q.size() != 0) begin
               nb = feed_q.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= nb.data;
               req_in_last <= nb.last;
               if (idle_on && $urandom_range(0, 6) == 0)
                  src_gap = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      int         hold_seen;
      int         hold_left;
      int         stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen = 0;
         hold_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.kind = kind_type'(rsp_token_kind);
            seen.value = rsp_token_value;
            seen.nest_level = rsp_nest_level;
            seen.status = status_type'(rsp_parse_status);
            seen.done = rsp_doc_done;
            if (int'(rsp_nest_level) > deepest)
               deepest = int'(rsp_nest_level);
            if (token_q.size() == 0) begin
               flag_error("unexpected beat", 64'(seen.kind), 64'(TK_NONE));
            end else begin
               want = token_q.pop_front();
               if (seen.kind !== want.kind)
                  flag_error("token_kind", 64'(seen.kind), 64'(want.kind));
               if (seen.value !== want.value)
                  flag_error("token_value", seen.value, want.value);
               if (seen.nest_level !== want.nest_level)
                  flag_error("nest_level", 64'(seen.nest_level), 64'(want.nest_level));
               if (seen.status !== want.status)
                  flag_error("parse_status", 64'(seen.status), 64'(want.status));
               if (seen.done !== want.done)
                  flag_error("doc_done", 64'(seen.done), 64'(want.done));
            end
            tokens_checked++;
         end
         // long hold on request, else random stall bursts
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles with %0d tokens outstanding",
               cycle_count, token_q.size());
      $display("bencode_token_parser regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      doc_restart();

      // directed: negative zero, trailing byte, bad key, short doc, leading zeros
      send_text("i-0e");
      send_text("lex");
      send_text("di");
      send_text("4:a");
      send_text("00");
      send_text("i05");
      send_text("e");
      put_text("2:");
      add_byte(8'h00);
      add_byte(8'hFF);
      send_doc(1'b0, 1'b1);
      send_text("d0:lee");

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // output held off while the sender keeps offering
      idle_on = 1'b0;
      hold_req++;
      feed_random(30, 1'b0);
      wait_drained();

      // empty budget: only zero-length strings, bare integers and empty containers pass
      set_budget(32'd0);
      feed_random(20, 1'b1);
      wait_drained();

      // full-range budget with long length fields
      set_budget(32'hFFFF_FFFF);
      put_text("4294967295:ab");
      send_doc(1'b0, 1'b1);
      put_long_len();
      send_doc(1'b0, 1'b1);
      feed_random(20, 1'b1);
      wait_drained();

      // tight budget
      set_budget(32'($urandom_range(4, 40)));
      feed_random(25, 1'b1);
      wait_drained();

      // budget lowered below what the open document already spent
      set_budget(32'd1000);
      put_text("l5:abcde3:xyz");
      send_doc(1'b0, 1'b0);
      wait_drained();
      set_budget(32'd4);
      send_text("i1ee");
      wait_drained();

      // default budget with nesting at and past the limit
      set_budget(BUDGET_RESET);
      put_deep(MAX_DEPTH, 1'b1);
      send_doc(1'b0, 1'b1);
      put_deep(MAX_DEPTH + 1, 1'b1);
      send_doc(1'b0, 1'b1);
      feed_random(25, 1'b1);
      wait_drained();

      set_budget($urandom);
      feed_random(20, 1'b1);
      wait_drained();

      // closing stretch at full rate
      set_budget(32'($urandom_range(20, 200)));
      feed_random(30, 1'b0);
      wait_drained();

      $display("drove %0d bytes in %0d documents, compared %0d tokens",
               bytes_sent, docs_sent, tokens_checked);
      $display("budget register written %0d times, deepest nesting reported %0d",
               budgets_set, deepest);
      if (errors == 0)
         $display("bencode_token_parser regression: pass");
      else
         $display("bencode_token_parser regression: fail");
      $finish;
   end

endmodule
